[design/frx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package frx_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;

  localparam logic [7:0] START_FIRST  = 8'hBC;
  localparam logic [7:0] START_SECOND = 8'hCF;

  typedef enum logic [1:0] {
    ST_PKT = 2'd0,
    ST_CK1 = 2'd1,
    ST_CK2 = 2'd2
  } frx_status_e;

  // Request from the parser to the delivery side, valid for one cycle.
  typedef struct packed {
    logic        start;
    frx_status_e kind;
  } frx_job_t;

  // Frame header and error counts; held steady while a frame is delivered.
  typedef struct packed {
    logic [7:0] pkt_type;
    logic [7:0] err1;
    logic [7:0] err2;
  } frx_info_t;

endpackage
`default_nettype wire

[design/frx_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
module frx_buf #(
  parameter int DEPTH = frx_pkg::MAX_PAYLOAD_DEF,
  parameter int AW    = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);
  import frx_pkg::*;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

  // The input side is stalled during delivery, so the ports never collide.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_i && rd_en_i))
    else $error("frame buffer written and read in the same cycle");

endmodule
`default_nettype wire

[design/frx_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
module frx_parser #(
  parameter int MAX_PAYLOAD = frx_pkg::MAX_PAYLOAD_DEF,
  parameter int CW          = 6,
  parameter int AW          = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   wr_en_o,
  output logic      [AW-1:0]     wr_addr_o,
  output logic      [7:0]        wr_data_o,
  output frx_pkg::frx_job_t      job_o,
  output frx_pkg::frx_info_t     info_o,
  output logic      [CW-1:0]     frame_len_o
);
  import frx_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT1  = 3'd0,
    PH_HUNT2  = 3'd1,
    PH_TYPE   = 3'd2,
    PH_LENGTH = 3'd3,
    PH_DATA   = 3'd4,
    PH_CK1    = 3'd5,
    PH_CK2    = 3'd6
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [7:0]    type_q, type_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    sum_a_q, sum_a_d;
  logic [7:0]    sum_b_q, sum_b_d;
  logic [7:0]    err1_q, err1_d;
  logic [7:0]    err2_q, err2_d;
  logic [7:0]    sum_a_nx;
  logic [CW-1:0] cnt_inc;

  assign sum_a_nx = sum_a_q + rx_byte_i;
  assign cnt_inc  = cnt_q + CW'(1);

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    err1_d    = err1_q;
    err2_d    = err2_q;
    wr_en_o   = 1'b0;
    wr_addr_o = AW'(cnt_q);
    wr_data_o = rx_byte_i;
    job_o     = '{start: 1'b0, kind: ST_PKT};
    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT2: begin
          phase_d = (rx_byte_i == START_SECOND) ? PH_TYPE : PH_HUNT1;
        end
        PH_TYPE: begin
          type_d  = rx_byte_i;
          sum_a_d = rx_byte_i;
          sum_b_d = rx_byte_i;
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_d   = CW'(rx_byte_i);
          sum_a_d = sum_a_nx;
          sum_b_d = sum_b_q + sum_a_nx;
          cnt_d   = '0;
          if (rx_byte_i > 8'(MAX_PAYLOAD)) begin
            phase_d = PH_HUNT1;
          end else if (rx_byte_i == 8'd0) begin
            phase_d = PH_CK1;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en_o = 1'b1;
          sum_a_d = sum_a_nx;
          sum_b_d = sum_b_q + sum_a_nx;
          cnt_d   = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CK1;
          end
        end
        PH_CK1: begin
          if (rx_byte_i == sum_a_q) begin
            phase_d = PH_CK2;
          end else begin
            err1_d  = err1_q + 8'd1;
            phase_d = PH_HUNT1;
            job_o   = '{start: 1'b1, kind: ST_CK1};
          end
        end
        PH_CK2: begin
          phase_d = PH_HUNT1;
          if (rx_byte_i == sum_b_q) begin
            job_o = '{start: 1'b1, kind: ST_PKT};
          end else begin
            err2_d = err2_q + 8'd1;
            job_o  = '{start: 1'b1, kind: ST_CK2};
          end
        end
        default: begin
          // The first hunt phase and the spare phase code both look for the first start byte.
          phase_d = (rx_byte_i == START_FIRST) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      type_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      err1_q  <= '0;
      err2_q  <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      err1_q  <= err1_d;
      err2_q  <= err2_d;
    end
  end

  assign info_o      = '{pkt_type: type_q, err1: err1_q, err2: err2_q};
  assign frame_len_o = len_q;

endmodule
`default_nettype wire

[design/frx_emit.sv]
`timescale 1ns / 1ps
`default_nettype none
module frx_emit #(
  parameter int CW = 6,
  parameter int AW = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire frx_pkg::frx_job_t job_i,
  input  wire logic [CW-1:0]     frame_len_i,
  output logic                   rd_en_o,
  output logic      [AW-1:0]     rd_addr_o,
  input  wire logic [7:0]        rd_data_i,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [1:0]        status_o,
  output logic      [4:0]        byte_index_o,
  output logic      [7:0]        data_byte_o,
  output logic                   last_o
);
  import frx_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE = 2'd0,
    E_READ = 2'd1,
    E_SHOW = 2'd2
  } emit_e;

  emit_e         state_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] cnt_inc;
  logic          out_valid_q;
  frx_status_e   status_q;
  logic [4:0]    index_q;
  logic [7:0]    data_q;
  logic          last_q;
  logic          direct;

  assign cnt_inc = cnt_q + CW'(1);
  // Errors and empty frames give one word without touching the buffer.
  assign direct  = (job_i.kind != ST_PKT) || (frame_len_i == '0);

  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    unique case (state_q)
      E_IDLE: begin
        rd_en_o = job_i.start && !direct;
      end
      E_SHOW: begin
        rd_en_o   = !out_stall_i && !last_q;
        rd_addr_o = AW'(cnt_inc);
      end
      default: begin
        rd_en_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_PKT;
      index_q     <= '0;
      data_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      unique case (state_q)
        E_IDLE: begin
          if (job_i.start) begin
            cnt_q <= '0;
            if (direct) begin
              status_q    <= job_i.kind;
              index_q     <= '0;
              data_q      <= '0;
              last_q      <= 1'b1;
              out_valid_q <= 1'b1;
              state_q     <= E_SHOW;
            end else begin
              state_q <= E_READ;
            end
          end
        end
        E_READ: begin
          status_q    <= ST_PKT;
          index_q     <= 5'(cnt_q);
          data_q      <= rd_data_i;
          last_q      <= (cnt_inc == frame_len_i);
          out_valid_q <= 1'b1;
          state_q     <= E_SHOW;
        end
        E_SHOW: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= E_IDLE;
            end else begin
              cnt_q   <= cnt_inc;
              state_q <= E_READ;
            end
          end
        end
        default: begin
          state_q <= E_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != E_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign byte_index_o = index_q;
  assign data_byte_o  = data_q;
  assign last_o       = last_q;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_PKT) |-> last_q)
    else $error("error word without last marker");

  a_read_before_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == E_READ) |-> $past(rd_en_o))
    else $error("buffer data taken without a read");

endmodule
`default_nettype wire

[design/framed_packet_receiver_fletcher8.sv]
// Each received byte is taken while no frame's words are being delivered.
// An error word appears in the cycle after the failing checksum byte is taken.
// A good non-empty frame's first word passes the buffer read register, then the output
// register, after its second checksum byte; each later word takes the same path plus stall.
// Input is stalled after any checksum byte that yields words until the last is taken.
// Reset is asynchronous, active low; it clears control and counters, not the buffer.
`timescale 1ns / 1ps
`default_nettype none
module framed_packet_receiver_fletcher8 #(
  parameter int MAX_PAYLOAD = frx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [1:0] status_o,
  output logic      [7:0] pkt_type_o,
  output logic      [5:0] pkt_length_o,
  output logic      [4:0] byte_index_o,
  output logic      [7:0] data_byte_o,
  output logic            last_o,
  output logic      [7:0] cksum1_errors_o,
  output logic      [7:0] cksum2_errors_o
);
  import frx_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic          accept;
  logic          busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  frx_job_t      job;
  frx_info_t     info;
  logic [CW-1:0] frame_len;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  frx_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .CW         (CW),
    .AW         (AW)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .job_o      (job),
    .info_o     (info),
    .frame_len_o(frame_len)
  );

  frx_buf #(
    .DEPTH(MAX_PAYLOAD),
    .AW   (AW)
  ) u_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  frx_emit #(
    .CW(CW),
    .AW(AW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .frame_len_i (frame_len),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .byte_index_o(byte_index_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o)
  );

  assign pkt_type_o      = info.pkt_type;
  assign pkt_length_o    = 6'(frame_len);
  assign cksum1_errors_o = info.err1;
  assign cksum2_errors_o = info.err2;

  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a word is pending");

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import frx_pkg::*;

  localparam int PAYLOAD_MAX = MAX_PAYLOAD_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_BYTES = 300;

  typedef enum logic [2:0] {
    PH_HUNT1, PH_HUNT2, PH_TYPE, PH_LEN, PH_DATA, PH_CK1, PH_CK2
  } parse_phase_e;

  typedef struct packed {
    frx_status_e status;
    logic [7:0]  pkt_type;
    logic [5:0]  pkt_length;
    logic [4:0]  byte_index;
    logic [7:0]  data_byte;
    logic        last;
    logic [7:0]  ck1_errs;
    logic [7:0]  ck2_errs;
  } frame_word_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    frame_word_t want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] pkt_type_o;
  logic [5:0] pkt_length_o;
  logic [4:0] byte_index_o;
  logic [7:0] data_byte_o;
  logic       last_o;
  logic [7:0] cksum1_errors_o;
  logic [7:0] cksum2_errors_o;

  framed_packet_receiver_fletcher8 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .pkt_type_o     (pkt_type_o),
    .pkt_length_o   (pkt_length_o),
    .byte_index_o   (byte_index_o),
    .data_byte_o    (data_byte_o),
    .last_o         (last_o),
    .cksum1_errors_o(cksum1_errors_o),
    .cksum2_errors_o(cksum2_errors_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Directed frames: empty good frame, first and second checksum errors,
  // an oversized length, a broken start pair and a one-byte frame.
  stim_row_t directed_rows [0:30] = '{
    '{8'hBC, 1'b0, '0}, '{8'hCF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{ST_PKT, 8'h00, 6'd0, 5'd0, 8'h00, 1'b1, 8'd0, 8'd0}},
    '{8'hBC, 1'b0, '0}, '{8'hCF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{ST_CK1, 8'hFF, 6'd0, 5'd0, 8'h00, 1'b1, 8'd1, 8'd0}},
    '{8'hBC, 1'b0, '0}, '{8'hCF, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b1, '{ST_CK2, 8'h01, 6'd0, 5'd0, 8'h00, 1'b1, 8'd1, 8'd1}},
    '{8'hBC, 1'b0, '0}, '{8'hCF, 1'b0, '0}, '{8'h05, 1'b0, '0}, '{8'h21, 1'b0, '0},
    '{8'hBC, 1'b0, '0}, '{8'hBC, 1'b0, '0}, '{8'hCF, 1'b0, '0},
    '{8'hBC, 1'b0, '0}, '{8'hCF, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h81, 1'b0, '0}
  };

  frame_word_t  frame_words_due[$];
  int           mismatch_count = 0;
  int           words_seen = 0;
  logic         gaps_on = 1'b1;
  logic         hold_req = 1'b0;
  logic         hold_taken = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  // Shadow state of the frame parser.
  parse_phase_e phase = PH_HUNT1;
  logic [7:0]   fr_type = 8'h00;
  logic [7:0]   fr_len = 8'h00;
  int           fill = 0;
  logic [7:0]   sum_a = 8'h00;
  logic [7:0]   sum_b = 8'h00;
  logic [7:0]   fr_data [PAYLOAD_MAX];
  logic [7:0]   ck1_errs = 8'h00;
  logic [7:0]   ck2_errs = 8'h00;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 200) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void push_word(input frx_status_e st, input logic [4:0] idx,
                                    input logic [7:0] d, input logic lst);
    frame_words_due.push_back('{st, fr_type, fr_len[5:0], idx, d, lst, ck1_errs, ck2_errs});
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    int i;
    case (phase)
      PH_HUNT2: phase = (b == START_SECOND) ? PH_TYPE : PH_HUNT1;
      PH_TYPE: begin
        fr_type = b;
        sum_a = b;
        sum_b = b;
        phase = PH_LEN;
      end
      PH_LEN: begin
        fr_len = b;
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
        fill = 0;
        if (b > PAYLOAD_MAX) phase = PH_HUNT1;
        else if (b == 8'h00) phase = PH_CK1;
        else phase = PH_DATA;
      end
      PH_DATA: begin
        if (fill < PAYLOAD_MAX) begin
          fr_data[fill] = b;
          sum_a = sum_a + b;
          sum_b = sum_b + sum_a;
        end
        fill++;
        if (fill >= fr_len) phase = PH_CK1;
      end
      PH_CK1: begin
        if (b == sum_a) begin
          phase = PH_CK2;
        end else begin
          ck1_errs = ck1_errs + 8'd1;
          phase = PH_HUNT1;
          push_word(ST_CK1, 5'd0, 8'h00, 1'b1);
        end
      end
      PH_CK2: begin
        phase = PH_HUNT1;
        if (b != sum_b) begin
          ck2_errs = ck2_errs + 8'd1;
          push_word(ST_CK2, 5'd0, 8'h00, 1'b1);
        end else if (fr_len == 8'h00) begin
          push_word(ST_PKT, 5'd0, 8'h00, 1'b1);
        end else begin
          for (i = 0; i < fr_len && i < PAYLOAD_MAX; i++)
            push_word(ST_PKT, 5'(i), fr_data[i], (i + 1 == fr_len));
        end
      end
      default: phase = (b == START_FIRST) ? PH_HUNT2 : PH_HUNT1;
    endcase
  endtask

  // Offers one byte, holds it until taken, then predicts the words it causes.
  task automatic send_word(input logic [7:0] b, output int made);
    int prior_cnt;
    if (gaps_on && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 31);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    prior_cnt = frame_words_due.size();
    deframe_byte(b);
    made = frame_words_due.size() - prior_cnt;
  endtask

  task automatic await_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frame_words_due.size() != 0);
  endtask

  // Builds one random frame (good, corrupted, oversized or cut short) or noise.
  task automatic send_frame(input logic force_full, inout int counted);
    logic [7:0] seq[$];
    logic [7:0] typ, len, d, a, s;
    int         pick, k, made;
    pick = force_full ? 0 : $urandom_range(99);
    if (pick >= 92) begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom));
    end else begin
      typ = 8'($urandom);
      if (force_full) len = 8'(PAYLOAD_MAX);
      else if (pick >= 78 && pick < 86) len = 8'($urandom_range(PAYLOAD_MAX + 1, 255));
      else if ($urandom_range(19) == 0) len = 8'(PAYLOAD_MAX);
      else if ($urandom_range(9) == 0) len = 8'($urandom_range(9, PAYLOAD_MAX));
      else len = 8'($urandom_range(8));
      seq = {START_FIRST, START_SECOND, typ, len};
      a = typ + len;
      s = typ + a;
      if (pick < 78 || pick >= 86) begin
        for (k = 0; k < len; k++) begin
          d = 8'($urandom);
          seq.push_back(d);
          a = a + d;
          s = s + a;
        end
        if (pick >= 60 && pick < 70) a = a ^ 8'($urandom_range(1, 255));
        if (pick >= 70 && pick < 78) s = s ^ 8'($urandom_range(1, 255));
        seq.push_back(a);
        seq.push_back(s);
        if (pick >= 86) seq = seq[0:$urandom_range(seq.size() - 2)];
      end
      counted += seq.size();
    end
    foreach (seq[k]) send_word(seq[k], made);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("word %0d %s: got %0h, expected %0h", words_seen, name,
                              got, want));
  endtask

  task automatic check_delivered_word();
    frame_word_t w;
    if (frame_words_due.size() == 0) begin
      flag_mismatch($sformatf("word %0d delivered with nothing expected", words_seen));
    end else begin
      w = frame_words_due.pop_front();
      compare_field("status", 8'(status_o), 8'(w.status));
      compare_field("pkt_type", pkt_type_o, w.pkt_type);
      compare_field("pkt_length", 8'(pkt_length_o), 8'(w.pkt_length));
      compare_field("byte_index", 8'(byte_index_o), 8'(w.byte_index));
      compare_field("data_byte", data_byte_o, w.data_byte);
      compare_field("last", 8'(last_o), 8'(w.last));
      compare_field("cksum1_errors", cksum1_errors_o, w.ck1_errs);
      compare_field("cksum2_errors", cksum2_errors_o, w.ck2_errs);
    end
    words_seen++;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_delivered_word();
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= gaps_on && ($urandom_range(99) < 31);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int made;
    int rand_bytes;
    rand_bytes = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].rx, made);
      if (directed_rows[r].typed) begin
        if (made > 0) void'(frame_words_due.pop_back());
        frame_words_due.push_back(directed_rows[r].want);
      end
    end
    await_drain();

    // The bench holds the output off while a full-size frame arrives, so the input
    // backs up behind the delivery.
    hold_req <= 1'b1;
    send_frame(1'b1, rand_bytes);
    while (rand_bytes < RANDOM_BYTES) begin
      gaps_on <= !(rand_bytes >= 120 && rand_bytes < 200);
      send_frame(1'b0, rand_bytes);
    end
    await_drain();
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
